// File: sv/pulse_width_ook_transmitter_macros.svh
// Assertion macros for the pulse-width OOK transmitter.
// No dependencies; included by the checker module.
`ifndef PULSE_WIDTH_OOK_TRANSMITTER_MACROS_SVH
`define PULSE_WIDTH_OOK_TRANSMITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PWOOK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("pwook assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PWOOK_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("pwook assertion failed");

`endif

// File: sv/pwook_pkg.sv
// Package for the pulse-width OOK transmitter: payload and config types,
// codes, sizing constants and helpers. No dependencies.
package pwook_pkg;

	localparam int MAX_FRAME_BYTES = 8;
	localparam int BIT_W           = $clog2(MAX_FRAME_BYTES * 8 + 1);
	localparam int BYTE_IDX_W      = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_START = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MARK_ONE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MARK_ZERO  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPACE_ONE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPACE_ZERO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAP        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN  = 3'd7;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] byte_index;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic finished;
	} result_t;

	typedef struct packed {
		logic [15:0] mark_one_ticks;
		logic [15:0] mark_zero_ticks;
		logic [15:0] space_one_ticks;
		logic [15:0] space_zero_ticks;
		logic [15:0] warmup_ticks;
		logic [15:0] gap_ticks;
		logic [7:0]  repeat_count;
		logic [3:0]  frame_bytes;
	} cfg_t;

	function automatic logic [15:0] min_one16(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

endpackage

// File: sv/pulse_width_ook_transmitter.sv
// Top level of the pulse-width OOK transmitter: input register, core, result register.
// Depends on pwook_pkg, pwook_cfg_regs and pwook_core.
//
// channel | signals                        | beat moves when
// item    | item_valid item_stall item     | item_valid && !item_stall
// result  | result_valid result_stall result | result_valid && !result_stall
// cfg     | cfg_valid cfg_ready cfg_index cfg_data | cfg_valid && cfg_ready
//
// One item per clock while the result is not stalled; an item beat reaches its result beat through
// the input register, then the state update into the result register.
// Throughput is set by the single state update per item in pwook_core.
// Reset clears sequencing state and config to defaults; frame bytes stay undefined.
// A stalled result holds the result register; the input register then holds too,
// and item_stall rises once it is full.
module pulse_width_ook_transmitter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  pwook_pkg::item_t                 item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output pwook_pkg::result_t               result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pwook_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pwook_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pwook_pkg::*;

	logic    item_valid_s1;
	item_t   item_s1;
	logic    result_valid_q;
	result_t result_q;
	result_t res;
	cfg_t    cfg;
	logic    advance;

	assign advance    = item_valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = item_valid_s1 && !advance;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall)
			item_s1 <= item;
	end

	pwook_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	pwook_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= res;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: sv/pwook_cfg_regs.sv
// Configuration register file of the pulse-width OOK transmitter.
// Depends on pwook_pkg.
module pwook_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [pwook_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [pwook_pkg::CFG_DATA_W-1:0] wr_data,
	output pwook_pkg::cfg_t                cfg
);
	import pwook_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mark_one_ticks   <= 16'd2500;
			cfg_q.mark_zero_ticks  <= 16'd7500;
			cfg_q.space_one_ticks  <= 16'd2500;
			cfg_q.space_zero_ticks <= 16'd2500;
			cfg_q.warmup_ticks     <= 16'd2500;
			cfg_q.gap_ticks        <= 16'd10000;
			cfg_q.repeat_count     <= 8'd3;
			cfg_q.frame_bytes      <= 4'd8;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MARK_ONE:   cfg_q.mark_one_ticks   <= wr_data;
				REG_MARK_ZERO:  cfg_q.mark_zero_ticks  <= wr_data;
				REG_SPACE_ONE:  cfg_q.space_one_ticks  <= wr_data;
				REG_SPACE_ZERO: cfg_q.space_zero_ticks <= wr_data;
				REG_WARMUP:     cfg_q.warmup_ticks     <= wr_data;
				REG_GAP:        cfg_q.gap_ticks        <= wr_data;
				REG_REPEAT:     cfg_q.repeat_count     <= wr_data[7:0];
				REG_FRAME_LEN:  cfg_q.frame_bytes      <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/pwook_core.sv
// Sequencing state, frame store and next-state logic of the OOK transmitter.
// Depends on pwook_pkg.
module pwook_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  pwook_pkg::item_t   item,
	input  pwook_pkg::cfg_t    cfg,
	output pwook_pkg::result_t res
);
	import pwook_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_LEAD  = 2'd1;
	localparam logic [1:0] PH_MARK  = 2'd2;
	localparam logic [1:0] PH_SPACE = 2'd3;

	logic [7:0]       store_q [MAX_FRAME_BYTES];
	logic [1:0]       phase_q, phase_d;
	logic [BIT_W-1:0] bit_pos_q, bit_pos_d;
	logic [7:0]       frames_q, frames_d;
	logic [15:0]      ticks_q, ticks_d;

	logic                  store_we;
	logic [BIT_W-4:0]      byte_sel;
	logic [2:0]            bit_sel;
	logic                  cur_bit;
	logic [3:0]            n_bytes;
	logic [BIT_W-1:0]      frame_bits;
	logic [BIT_W-1:0]      bit_next;
	logic [15:0]           ticks_dec;
	logic [7:0]            frames_dec;
	logic                  done;

	assign byte_sel = bit_pos_q[BIT_W-1:3];
	assign bit_sel  = bit_pos_q[2:0];
	assign cur_bit  = (int'(byte_sel) < MAX_FRAME_BYTES) ?
		store_q[byte_sel[BYTE_IDX_W-1:0]][3'd7 - bit_sel] : 1'b0;

	always_comb begin
		if (cfg.frame_bytes == 4'd0)
			n_bytes = 4'd1;
		else if (int'(cfg.frame_bytes) > MAX_FRAME_BYTES)
			n_bytes = 4'(MAX_FRAME_BYTES);
		else
			n_bytes = cfg.frame_bytes;
	end

	assign frame_bits = BIT_W'(n_bytes) << 3;
	assign bit_next   = bit_pos_q + 1'b1;
	assign ticks_dec  = (ticks_q != 16'd0) ? ticks_q - 16'd1 : ticks_q;
	assign frames_dec = (frames_q != 8'd0) ? frames_q - 8'd1 : frames_q;

	always_comb begin
		phase_d   = phase_q;
		bit_pos_d = bit_pos_q;
		frames_d  = frames_q;
		ticks_d   = ticks_q;
		store_we  = 1'b0;
		done      = 1'b0;
		unique case (item.mode)
			MODE_WRITE: begin
				store_we = (phase_q == PH_IDLE) && (int'(item.byte_index) < MAX_FRAME_BYTES);
			end
			MODE_START: begin
				if (phase_q == PH_IDLE) begin
					phase_d   = PH_LEAD;
					ticks_d   = min_one16(cfg.warmup_ticks);
					frames_d  = (cfg.repeat_count == 8'd0) ? 8'd1 : cfg.repeat_count;
					bit_pos_d = '0;
				end
			end
			MODE_TICK: begin
				if (phase_q != PH_IDLE) begin
					ticks_d = ticks_dec;
					if (ticks_dec == 16'd0) begin
						if (phase_q != PH_MARK) begin
							phase_d = PH_MARK;
							ticks_d = min_one16(cur_bit ? cfg.mark_one_ticks
								: cfg.mark_zero_ticks);
						end else if (bit_next < frame_bits) begin
							bit_pos_d = bit_next;
							phase_d   = PH_SPACE;
							ticks_d   = min_one16(cur_bit ? cfg.space_one_ticks
								: cfg.space_zero_ticks);
						end else begin
							bit_pos_d = '0;
							frames_d  = frames_dec;
							if (frames_dec == 8'd0) begin
								phase_d = PH_IDLE;
								ticks_d = 16'd0;
								done    = 1'b1;
							end else begin
								phase_d = PH_LEAD;
								ticks_d = min_one16(cfg.gap_ticks);
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_pos_q <= '0;
			frames_q  <= 8'd0;
			ticks_q   <= 16'd0;
		end else if (advance) begin
			phase_q   <= phase_d;
			bit_pos_q <= bit_pos_d;
			frames_q  <= frames_d;
			ticks_q   <= ticks_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && store_we)
			store_q[item.byte_index[BYTE_IDX_W-1:0]] <= item.byte_value;
	end

	assign res.line_level = (phase_q == PH_MARK);
	assign res.busy_res   = (phase_d != PH_IDLE);
	assign res.finished   = done;

endmodule

// File: sv/pwook_checker.sv
// Port-level checker for the pulse-width OOK transmitter, bound to the top level.
// Depends on pwook_pkg and pulse_width_ook_transmitter_macros.svh.
`include "pulse_width_ook_transmitter_macros.svh"

module pwook_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input pwook_pkg::result_t result
);
	import pwook_pkg::*;

	`PWOOK_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result))
	`PWOOK_ASSERT_IMP(a_done_not_busy, clk, arst_n, result_valid && result.finished, !result.busy_res)
	`PWOOK_ASSERT_IMP(a_done_mark, clk, arst_n, result_valid && result.finished, result.line_level)
	`PWOOK_ASSERT_IMP(a_stall_cause, clk, arst_n, item_stall, result_valid && result_stall)

endmodule

bind pulse_width_ook_transmitter pwook_checker u_pwook_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
